// File: rtl/core/trapezoid_pulse_waveform_generator_unit_assert.svh
// ---------------------------------------------------------------------------
// Trapezoid pulse generator assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef TRAPEZOID_PULSE_WAVEFORM_GENERATOR_UNIT_ASSERT_SVH
`define TRAPEZOID_PULSE_WAVEFORM_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TPWG_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpwg: implication check failed");

// next-cycle implication
`define TPWG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpwg: next-cycle check failed");

`endif

// File: rtl/core/tpwg_pkg.sv
// ---------------------------------------------------------------------------
// Trapezoid pulse generator package
// Shared constants, register map and control word type.
// ---------------------------------------------------------------------------
`default_nettype none

package tpwg_pkg;

	localparam int TIME_BITS_DEF  = 48;
	localparam int LEVEL_BITS_DEF = 32;

	localparam int APB_AW = 6;
	localparam int APB_DW = 64;

	localparam logic [2:0] REG_START_DELAY   = 3'd0;
	localparam logic [2:0] REG_LOW_LEVEL     = 3'd1;
	localparam logic [2:0] REG_HIGH_LEVEL    = 3'd2;
	localparam logic [2:0] REG_REPEAT_PERIOD = 3'd3;
	localparam logic [2:0] REG_RISE_TIME     = 3'd4;
	localparam logic [2:0] REG_FALL_TIME     = 3'd5;
	localparam logic [2:0] REG_TOP_WIDTH     = 3'd6;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_RISE   = 2'd1;
	localparam logic [1:0] ERR_PERIOD = 2'd2;

	typedef struct packed {
		logic       is_edge;
		logic       has_brk;
		logic [1:0] err;
	} tpwg_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/tpwg_ifs.sv
// ---------------------------------------------------------------------------
// Trapezoid pulse generator channels
// Valid/ready channels for sample times and generated results.
// ---------------------------------------------------------------------------
`default_nettype none

interface tpwg_smp_if #(parameter int TIME_BITS = 48);
	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] sample_time;

	modport source (output valid, output sample_time, input ready);
	modport sink   (input valid, input sample_time, output ready);
endinterface

interface tpwg_res_if #(parameter int TIME_BITS = 48, parameter int LEVEL_BITS = 32);
	logic                         valid;
	logic                         ready;
	logic signed [LEVEL_BITS-1:0] level;
	logic [TIME_BITS-1:0]         next_break;
	logic                         has_next_break;
	logic [1:0]                   config_error;

	modport source (output valid, output level, output next_break,
		output has_next_break, output config_error, input ready);
	modport sink   (input valid, input level, input next_break,
		input has_next_break, input config_error, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tpwg_cfg.sv
// ---------------------------------------------------------------------------
// Trapezoid pulse generator register file
// APB registers plus the derived error code and segment bounds.
// ---------------------------------------------------------------------------
`default_nettype none

module tpwg_cfg
	import tpwg_pkg::*;
#(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_AW-1:0]     paddr,
	input  wire logic [APB_DW-1:0]     pwdata,
	output logic      [APB_DW-1:0]     prdata,
	output logic                       pready,
	output logic      [TIME_BITS-1:0]  start_delay,
	output logic      [LEVEL_BITS-1:0] low_level,
	output logic      [LEVEL_BITS-1:0] high_level,
	output logic      [TIME_BITS-1:0]  repeat_period,
	output logic      [TIME_BITS-1:0]  rise_time,
	output logic      [TIME_BITS-1:0]  fall_time,
	output logic      [1:0]            err,
	output logic      [TIME_BITS:0]    bnd_top,
	output logic      [TIME_BITS+1:0]  bnd_fall
);

	localparam logic [LEVEL_BITS-1:0] HIGH_RST = LEVEL_BITS'(65536);
	localparam logic [TIME_BITS-1:0]  RISE_RST = TIME_BITS'(1000);

	logic [TIME_BITS-1:0]  start_delay_q, period_q, rise_q, fall_q, top_q;
	logic [LEVEL_BITS-1:0] low_q, high_q;
	logic [1:0]            err_q;
	logic [TIME_BITS:0]    bnd_top_q;
	logic [TIME_BITS+1:0]  bnd_fall_q;
	logic [2:0]            idx;
	logic                  wr;
	logic [TIME_BITS+1:0]  sum3;
	logic [TIME_BITS-1:0]  sum_sat;
	logic [1:0]            err_d;

	assign idx    = paddr[APB_AW-1:3];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delay_q <= '0;
			low_q         <= '0;
			high_q        <= HIGH_RST;
			period_q      <= '0;
			rise_q        <= RISE_RST;
			fall_q        <= '0;
			top_q         <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_START_DELAY:   start_delay_q <= pwdata[TIME_BITS-1:0];
				REG_LOW_LEVEL:     low_q         <= pwdata[LEVEL_BITS-1:0];
				REG_HIGH_LEVEL:    high_q        <= pwdata[LEVEL_BITS-1:0];
				REG_REPEAT_PERIOD: period_q      <= pwdata[TIME_BITS-1:0];
				REG_RISE_TIME:     rise_q        <= pwdata[TIME_BITS-1:0];
				REG_FALL_TIME:     fall_q        <= pwdata[TIME_BITS-1:0];
				REG_TOP_WIDTH:     top_q         <= pwdata[TIME_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_START_DELAY:   prdata = APB_DW'(start_delay_q);
			REG_LOW_LEVEL:     prdata = APB_DW'(signed'(low_q));
			REG_HIGH_LEVEL:    prdata = APB_DW'(signed'(high_q));
			REG_REPEAT_PERIOD: prdata = APB_DW'(period_q);
			REG_RISE_TIME:     prdata = APB_DW'(rise_q);
			REG_FALL_TIME:     prdata = APB_DW'(fall_q);
			REG_TOP_WIDTH:     prdata = APB_DW'(top_q);
			default:           prdata = '0;
		endcase
	end

	// a nonzero period must exceed rise+fall+width, sum saturating at the tick range
	assign sum3    = {2'b00, rise_q} + {2'b00, fall_q} + {2'b00, top_q};
	assign sum_sat = (|sum3[TIME_BITS+1:TIME_BITS]) ? '1 : sum3[TIME_BITS-1:0];

	always_comb begin
		priority if (rise_q == '0)
			err_d = ERR_RISE;
		else if (period_q != '0 && period_q <= sum_sat)
			err_d = ERR_PERIOD;
		else
			err_d = ERR_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) err_q <= ERR_NONE;
		else         err_q <= err_d;
	end

	always_ff @(posedge clk) begin
		bnd_top_q  <= {1'b0, rise_q} + {1'b0, top_q};
		bnd_fall_q <= sum3;
	end

	assign start_delay   = start_delay_q;
	assign low_level     = low_q;
	assign high_level    = high_q;
	assign repeat_period = period_q;
	assign rise_time     = rise_q;
	assign fall_time     = fall_q;
	assign err           = err_q;
	assign bnd_top       = bnd_top_q;
	assign bnd_fall      = bnd_fall_q;

endmodule

`default_nettype wire

// File: rtl/core/tpwg_mod.sv
// ---------------------------------------------------------------------------
// Trapezoid pulse generator phase stage
// Elapsed time since the delay, reduced modulo the period one bit a stage.
// ---------------------------------------------------------------------------
`default_nettype none

module tpwg_mod
	import tpwg_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 i_vld,
	input  wire logic [TIME_BITS-1:0] i_t,
	input  wire logic [TIME_BITS-1:0] start_delay,
	input  wire logic [TIME_BITS-1:0] repeat_period,
	output logic                      o_vld,
	output logic      [TIME_BITS-1:0] o_t,
	output logic                      o_pre,
	output logic      [TIME_BITS-1:0] o_el
);

	logic                 vld_s [0:TIME_BITS];
	logic [TIME_BITS-1:0] t_s   [0:TIME_BITS];
	logic                 pre_s [0:TIME_BITS];
	logic [TIME_BITS-1:0] el0_s [0:TIME_BITS];
	logic [TIME_BITS-1:0] rem_s [0:TIME_BITS];

	for (genvar k = 0; k <= TIME_BITS; k++) begin : g_stage
		if (k == 0) begin : g_entry
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)  vld_s[0] <= 1'b0;
				else if (en) vld_s[0] <= i_vld;
			end
			always_ff @(posedge clk) begin
				if (en) begin
					t_s[0]   <= i_t;
					pre_s[0] <= i_t < start_delay;
					el0_s[0] <= i_t - start_delay;
					rem_s[0] <= '0;
				end
			end
		end else begin : g_div
			logic [TIME_BITS:0] sh, nxt;
			// shift in the next dividend bit, subtract when it fits
			assign sh  = {rem_s[k-1], el0_s[k-1][TIME_BITS-k]};
			assign nxt = (sh >= {1'b0, repeat_period}) ? sh - {1'b0, repeat_period} : sh;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)  vld_s[k] <= 1'b0;
				else if (en) vld_s[k] <= vld_s[k-1];
			end
			always_ff @(posedge clk) begin
				if (en) begin
					t_s[k]   <= t_s[k-1];
					pre_s[k] <= pre_s[k-1];
					el0_s[k] <= el0_s[k-1];
					rem_s[k] <= nxt[TIME_BITS-1:0];
				end
			end
		end
	end

	assign o_vld = vld_s[TIME_BITS];
	assign o_t   = t_s[TIME_BITS];
	assign o_pre = pre_s[TIME_BITS];
	assign o_el  = (repeat_period == '0) ? el0_s[TIME_BITS] : rem_s[TIME_BITS];

endmodule

`default_nettype wire

// File: rtl/core/tpwg_seg.sv
// ---------------------------------------------------------------------------
// Trapezoid pulse generator segment decode
// Picks the pulse segment, edge operands and the next corner time.
// ---------------------------------------------------------------------------
`default_nettype none

module tpwg_seg
	import tpwg_pkg::*;
#(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  i_vld,
	input  wire logic [TIME_BITS-1:0]  i_t,
	input  wire logic                  i_pre,
	input  wire logic [TIME_BITS-1:0]  i_el,
	input  wire logic [TIME_BITS-1:0]  start_delay,
	input  wire logic [LEVEL_BITS-1:0] low_level,
	input  wire logic [LEVEL_BITS-1:0] high_level,
	input  wire logic [TIME_BITS-1:0]  repeat_period,
	input  wire logic [TIME_BITS-1:0]  rise_time,
	input  wire logic [TIME_BITS-1:0]  fall_time,
	input  wire logic [1:0]            err,
	input  wire logic [TIME_BITS:0]    bnd_top,
	input  wire logic [TIME_BITS+1:0]  bnd_fall,
	output logic                       o_vld,
	output tpwg_ctl_t                  o_ctl,
	output logic      [TIME_BITS-1:0]  o_brk,
	output logic      [TIME_BITS-1:0]  o_e,
	output logic      [TIME_BITS-1:0]  o_d,
	output logic      [LEVEL_BITS-1:0] o_from,
	output logic                       o_neg,
	output logic      [LEVEL_BITS-1:0] o_mag,
	output logic      [LEVEL_BITS-1:0] o_lvl
);

	logic                  lt_rise, lt_top, lt_fall, add_t;
	logic [TIME_BITS+1:0]  elx, off_top, rem;
	tpwg_ctl_t             ctl;
	logic [TIME_BITS-1:0]  e, d;
	logic [LEVEL_BITS-1:0] from, to, lvl;

	logic                  vld_s1, vld_s2;
	tpwg_ctl_t             ctl_s1, ctl_s2;
	logic [TIME_BITS-1:0]  base_s1, e_s1, d_s1, e_s2, d_s2, brk_s2;
	logic [TIME_BITS+1:0]  rem_s1;
	logic [LEVEL_BITS-1:0] from_s1, to_s1, lvl_s1, from_s2, mag_s2, lvl_s2;
	logic                  neg_s2;

	logic [TIME_BITS+2:0]  sum;
	logic [TIME_BITS-1:0]  brk;
	logic [LEVEL_BITS:0]   diff, mag_full;

	assign elx     = {2'b00, i_el};
	assign off_top = elx - {1'b0, bnd_top};
	assign lt_rise = i_el < rise_time;
	assign lt_top  = elx < {1'b0, bnd_top};
	assign lt_fall = elx < bnd_fall;

	always_comb begin
		ctl         = '0;
		ctl.err     = err;
		add_t       = 1'b1;
		rem         = '0;
		e           = i_el;
		d           = rise_time;
		from        = low_level;
		to          = high_level;
		lvl         = low_level;
		priority if (err != ERR_NONE) begin
			add_t = 1'b0;
		end else if (i_pre) begin
			ctl.has_brk = 1'b1;
			add_t       = 1'b0;
			rem         = {2'b00, start_delay};
		end else if (lt_rise) begin
			ctl.is_edge = 1'b1;
			ctl.has_brk = 1'b1;
			rem         = {2'b00, rise_time - i_el};
		end else if (lt_top) begin
			lvl         = high_level;
			ctl.has_brk = 1'b1;
			rem         = {1'b0, bnd_top} - elx;
		end else if (fall_time == '0) begin
			// zero fall: hold the top level, no corner
			lvl = high_level;
		end else if (lt_fall) begin
			ctl.is_edge = 1'b1;
			ctl.has_brk = 1'b1;
			e           = off_top[TIME_BITS-1:0];
			d           = fall_time;
			from        = high_level;
			to          = low_level;
			rem         = bnd_fall - elx;
		end else if (repeat_period != '0) begin
			ctl.has_brk = 1'b1;
			rem         = {2'b00, repeat_period - i_el};
		end else begin
			add_t = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= i_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= ctl;
			base_s1 <= add_t ? i_t : '0;
			rem_s1  <= rem;
			e_s1    <= e;
			d_s1    <= d;
			from_s1 <= from;
			to_s1   <= to;
			lvl_s1  <= lvl;
		end
	end

	// saturate the corner time at the top of the tick range
	assign sum      = {3'b000, base_s1} + {1'b0, rem_s1};
	assign brk      = (|sum[TIME_BITS+2:TIME_BITS]) ? '1 : sum[TIME_BITS-1:0];
	assign diff     = {to_s1[LEVEL_BITS-1], to_s1} - {from_s1[LEVEL_BITS-1], from_s1};
	assign mag_full = diff[LEVEL_BITS] ? -diff : diff;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2  <= ctl_s1;
			brk_s2  <= ctl_s1.has_brk ? brk : '0;
			e_s2    <= e_s1;
			d_s2    <= d_s1;
			from_s2 <= from_s1;
			neg_s2  <= diff[LEVEL_BITS];
			mag_s2  <= mag_full[LEVEL_BITS-1:0];
			lvl_s2  <= lvl_s1;
		end
	end

	assign o_vld  = vld_s2;
	assign o_ctl  = ctl_s2;
	assign o_brk  = brk_s2;
	assign o_e    = e_s2;
	assign o_d    = d_s2;
	assign o_from = from_s2;
	assign o_neg  = neg_s2;
	assign o_mag  = mag_s2;
	assign o_lvl  = lvl_s2;

endmodule

`default_nettype wire

// File: rtl/core/tpwg_interp.sv
// ---------------------------------------------------------------------------
// Trapezoid pulse generator edge interpolator
// floor(e * mag / d) one magnitude bit a stage, then the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tpwg_interp
	import tpwg_pkg::*;
#(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  i_vld,
	input  wire tpwg_ctl_t             i_ctl,
	input  wire logic [TIME_BITS-1:0]  i_brk,
	input  wire logic [TIME_BITS-1:0]  i_e,
	input  wire logic [TIME_BITS-1:0]  i_d,
	input  wire logic [LEVEL_BITS-1:0] i_from,
	input  wire logic                  i_neg,
	input  wire logic [LEVEL_BITS-1:0] i_mag,
	input  wire logic [LEVEL_BITS-1:0] i_lvl,
	output logic                       o_vld,
	output logic      [LEVEL_BITS-1:0] o_level,
	output logic      [TIME_BITS-1:0]  o_brk,
	output logic                       o_has,
	output logic      [1:0]            o_err
);

	logic                  vld_s  [1:LEVEL_BITS];
	tpwg_ctl_t             ctl_s  [1:LEVEL_BITS];
	logic [TIME_BITS-1:0]  brk_s  [1:LEVEL_BITS];
	logic [TIME_BITS-1:0]  e_s    [1:LEVEL_BITS];
	logic [TIME_BITS-1:0]  d_s    [1:LEVEL_BITS];
	logic [LEVEL_BITS-1:0] from_s [1:LEVEL_BITS];
	logic                  neg_s  [1:LEVEL_BITS];
	logic [LEVEL_BITS-1:0] mag_s  [1:LEVEL_BITS];
	logic [LEVEL_BITS-1:0] lvl_s  [1:LEVEL_BITS];
	logic [TIME_BITS-1:0]  rem_s  [1:LEVEL_BITS];
	logic [LEVEL_BITS-1:0] q_s    [1:LEVEL_BITS];

	logic                  vld_q;
	logic [LEVEL_BITS-1:0] level_q, qsum;
	logic [TIME_BITS-1:0]  brk_q;
	tpwg_ctl_t             ctl_q;

	for (genvar k = 1; k <= LEVEL_BITS; k++) begin : g_step
		logic                  vld_in, neg_in;
		tpwg_ctl_t             ctl_in;
		logic [TIME_BITS-1:0]  brk_in, e_in, d_in, rem_in;
		logic [LEVEL_BITS-1:0] from_in, mag_in, lvl_in, q_in, q_nx;
		logic [TIME_BITS+1:0]  s, d1, d2, rem_nx;
		logic                  ge1, ge2;

		if (k == 1) begin : g_src
			assign vld_in  = i_vld;
			assign ctl_in  = i_ctl;
			assign brk_in  = i_brk;
			assign e_in    = i_e;
			assign d_in    = i_d;
			assign from_in = i_from;
			assign neg_in  = i_neg;
			assign mag_in  = i_mag;
			assign lvl_in  = i_lvl;
			assign rem_in  = '0;
			assign q_in    = '0;
		end else begin : g_prev
			assign vld_in  = vld_s[k-1];
			assign ctl_in  = ctl_s[k-1];
			assign brk_in  = brk_s[k-1];
			assign e_in    = e_s[k-1];
			assign d_in    = d_s[k-1];
			assign from_in = from_s[k-1];
			assign neg_in  = neg_s[k-1];
			assign mag_in  = mag_s[k-1];
			assign lvl_in  = lvl_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign q_in    = q_s[k-1];
		end

		// rem < d and e < d, so 2*rem + e < 3*d: digit is 0, 1 or 2
		assign d1     = {2'b00, d_in};
		assign d2     = {1'b0, d_in, 1'b0};
		assign s      = {1'b0, rem_in, 1'b0} + (mag_in[LEVEL_BITS-k] ? {2'b00, e_in} : '0);
		assign ge2    = s >= d2;
		assign ge1    = s >= d1;
		assign rem_nx = ge2 ? s - d2 : (ge1 ? s - d1 : s);
		assign q_nx   = {q_in[LEVEL_BITS-2:0], 1'b0}
			+ {{(LEVEL_BITS-2){1'b0}}, ge2, ge1 && !ge2};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)  vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_s[k]  <= ctl_in;
				brk_s[k]  <= brk_in;
				e_s[k]    <= e_in;
				d_s[k]    <= d_in;
				from_s[k] <= from_in;
				neg_s[k]  <= neg_in;
				mag_s[k]  <= mag_in;
				lvl_s[k]  <= lvl_in;
				rem_s[k]  <= rem_nx[TIME_BITS-1:0];
				q_s[k]    <= q_nx;
			end
		end
	end

	// step from the start level toward the end level
	assign qsum = neg_s[LEVEL_BITS] ? from_s[LEVEL_BITS] - q_s[LEVEL_BITS]
		: from_s[LEVEL_BITS] + q_s[LEVEL_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)  vld_q <= 1'b0;
		else if (en) vld_q <= vld_s[LEVEL_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			level_q <= ctl_s[LEVEL_BITS].is_edge ? qsum : lvl_s[LEVEL_BITS];
			brk_q   <= brk_s[LEVEL_BITS];
			ctl_q   <= ctl_s[LEVEL_BITS];
		end
	end

	assign o_vld   = vld_q;
	assign o_level = level_q;
	assign o_brk   = brk_q;
	assign o_has   = ctl_q.has_brk;
	assign o_err   = ctl_q.err;

endmodule

`default_nettype wire

// File: rtl/core/trapezoid_pulse_waveform_generator_unit.sv
// ---------------------------------------------------------------------------
// Trapezoid pulse waveform generator
// Pulse level and next corner time for each sample time, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   smp carries one sample_time word per handshake; res returns one word per
//   sample: level (signed Q16.16), next_break, has_next_break, config_error.
//   Results come out in sample order.
//   The pipeline has one entry stage, one stage per time bit for the
//   reduction modulo the period, two segment decode stages, one stage per
//   level bit for the edge interpolation divide, and the output register.
//   Throughput is one word per cycle; a new sample is taken every cycle the
//   output register is empty or being drained.
//   The pulse settings sit in an APB register file (8-byte stride, 64-bit
//   data); write them only while the pipeline is empty.
//   Reset clears all pipeline valid bits and loads the register defaults.
//   When res is stalled the whole pipeline holds and smp.ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

`include "trapezoid_pulse_waveform_generator_unit_assert.svh"

module trapezoid_pulse_waveform_generator_unit
	import tpwg_pkg::*;
#(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	tpwg_smp_if.sink               smp,
	tpwg_res_if.source             res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	logic                  en;
	logic [TIME_BITS-1:0]  start_delay, repeat_period, rise_time, fall_time;
	logic [LEVEL_BITS-1:0] low_level, high_level;
	logic [1:0]            err;
	logic [TIME_BITS:0]    bnd_top;
	logic [TIME_BITS+1:0]  bnd_fall;

	logic                  m_vld, m_pre;
	logic [TIME_BITS-1:0]  m_t, m_el;

	logic                  g_vld, g_neg;
	tpwg_ctl_t             g_ctl;
	logic [TIME_BITS-1:0]  g_brk, g_e, g_d;
	logic [LEVEL_BITS-1:0] g_from, g_mag, g_lvl;

	logic                  o_vld, o_has;
	logic [LEVEL_BITS-1:0] o_level;
	logic [TIME_BITS-1:0]  o_brk;
	logic [1:0]            o_err;

	// advance everything unless a finished word is held at the output
	assign en        = !o_vld || res.ready;
	assign smp.ready = en;

	tpwg_cfg #(.TIME_BITS(TIME_BITS), .LEVEL_BITS(LEVEL_BITS)) u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.start_delay, .low_level, .high_level, .repeat_period, .rise_time, .fall_time,
		.err, .bnd_top, .bnd_fall
	);

	tpwg_mod #(.TIME_BITS(TIME_BITS)) u_mod (
		.clk, .arst_n, .en,
		.i_vld(smp.valid), .i_t(smp.sample_time),
		.start_delay, .repeat_period,
		.o_vld(m_vld), .o_t(m_t), .o_pre(m_pre), .o_el(m_el)
	);

	tpwg_seg #(.TIME_BITS(TIME_BITS), .LEVEL_BITS(LEVEL_BITS)) u_seg (
		.clk, .arst_n, .en,
		.i_vld(m_vld), .i_t(m_t), .i_pre(m_pre), .i_el(m_el),
		.start_delay, .low_level, .high_level, .repeat_period, .rise_time, .fall_time,
		.err, .bnd_top, .bnd_fall,
		.o_vld(g_vld), .o_ctl(g_ctl), .o_brk(g_brk), .o_e(g_e), .o_d(g_d),
		.o_from(g_from), .o_neg(g_neg), .o_mag(g_mag), .o_lvl(g_lvl)
	);

	tpwg_interp #(.TIME_BITS(TIME_BITS), .LEVEL_BITS(LEVEL_BITS)) u_interp (
		.clk, .arst_n, .en,
		.i_vld(g_vld), .i_ctl(g_ctl), .i_brk(g_brk), .i_e(g_e), .i_d(g_d),
		.i_from(g_from), .i_neg(g_neg), .i_mag(g_mag), .i_lvl(g_lvl),
		.o_vld, .o_level, .o_brk, .o_has, .o_err
	);

	assign res.valid          = o_vld;
	assign res.level          = o_level;
	assign res.next_break     = o_brk;
	assign res.has_next_break = o_has;
	assign res.config_error   = o_err;

	`TPWG_ASSERT_IMPLY(a_err_no_break, res.valid && res.config_error != ERR_NONE,
		!res.has_next_break && res.level == low_level)
	`TPWG_ASSERT_IMPLY(a_no_break_zero, res.valid && !res.has_next_break,
		res.next_break == '0)
	`TPWG_ASSERT_IMPLY(a_stall_blocks_input, res.valid && !res.ready, !smp.ready)
	`TPWG_ASSERT_NEXT(a_stall_holds_word, res.valid && !res.ready,
		res.valid && $stable(res.next_break) && $stable(res.level))

endmodule

`default_nettype wire

// File: sim/trapezoid_pulse_waveform_generator_unit_tb.sv
// ---------------------------------------------------------------------------
// Trapezoid pulse waveform generator testbench
// Streams sample times through the generator under several pulse settings,
// including extremes and rejected settings. The expected level, next corner
// and error code are computed in the bench for each accepted sample and
// compared in order with the returned words, under random source gaps and
// sink stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module trapezoid_pulse_waveform_generator_unit_tb;
	import tpwg_pkg::*;

	localparam int TB = 48;
	localparam int LB = 32;
	localparam logic [TB-1:0] TMAX = '1;

	typedef struct {
		logic [LB-1:0] level;
		logic [TB-1:0] next_break;
		logic          has_next_break;
		logic [1:0]    config_error;
	} pulse_word_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	wire  [APB_DW-1:0] prdata;
	wire               pready;

	tpwg_smp_if #(.TIME_BITS(TB)) smp_ch ();
	tpwg_res_if #(.TIME_BITS(TB), .LEVEL_BITS(LB)) res_ch ();

	trapezoid_pulse_waveform_generator_unit #(.TIME_BITS(TB), .LEVEL_BITS(LB)) uut (
		.clk(clk), .arst_n(arst_n), .smp(smp_ch), .res(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// bench copy of the pulse settings
	logic [TB-1:0] cfg_delay, cfg_period, cfg_rise, cfg_fall, cfg_width;
	logic [LB-1:0] cfg_low, cfg_high;

	logic [TB-1:0] sample_q[$];
	pulse_word_t   pulse_q[$];
	int            mismatch_count;
	logic          hold_send;
	int            burst_left, gap_left, stall_pct, stall_cnt;
	logic [TB-1:0] next_time;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(4 * 3000000);
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [TB-1:0] sat_sum(logic [TB-1:0] a, logic [TB-1:0] b);
		logic [TB:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TB] ? TMAX : s[TB-1:0];
	endfunction

	// level along an edge, truncated toward the starting level
	function automatic logic [LB-1:0] ramp(logic [LB-1:0] from_r, logic [LB-1:0] to_r,
			logic [TB-1:0] e, logic [TB-1:0] d);
		logic signed [LB+1:0] f, dlt;
		logic [LB+1:0] mag, r;
		logic [127:0] q;
		f = signed'({{2{from_r[LB-1]}}, from_r});
		dlt = signed'({{2{to_r[LB-1]}}, to_r}) - f;
		mag = dlt[LB+1] ? -dlt : dlt;
		q = ({{(128-TB){1'b0}}, e} * {{(126-LB){1'b0}}, mag}) / {{(128-TB){1'b0}}, d};
		r = dlt[LB+1] ? (f - q[LB+1:0]) : (f + q[LB+1:0]);
		return r[LB-1:0];
	endfunction

	function automatic pulse_word_t pulse_at(logic [TB-1:0] t);
		pulse_word_t w;
		logic [TB-1:0] el, e;
		w.level = cfg_low;
		w.next_break = '0;
		w.has_next_break = 1'b0;
		w.config_error = ERR_NONE;
		if (cfg_rise == 0)
			w.config_error = ERR_RISE;
		else if (cfg_period != 0 &&
				cfg_period <= sat_sum(sat_sum(cfg_rise, cfg_fall), cfg_width))
			w.config_error = ERR_PERIOD;
		if (w.config_error == ERR_NONE) begin
			if (t < cfg_delay) begin
				w.next_break = cfg_delay;
				w.has_next_break = 1'b1;
			end else begin
				el = t - cfg_delay;
				if (cfg_period != 0)
					el = el % cfg_period;
				e = el;
				if (e < cfg_rise) begin
					w.level = ramp(cfg_low, cfg_high, e, cfg_rise);
					w.next_break = sat_sum(t, cfg_rise - e);
					w.has_next_break = 1'b1;
				end else begin
					e = e - cfg_rise;
					if (e < cfg_width) begin
						w.level = cfg_high;
						w.next_break = sat_sum(t, cfg_width - e);
						w.has_next_break = 1'b1;
					end else begin
						e = e - cfg_width;
						if (cfg_fall == 0) begin
							w.level = cfg_high;
						end else if (e < cfg_fall) begin
							w.level = ramp(cfg_high, cfg_low, e, cfg_fall);
							w.next_break = sat_sum(t, cfg_fall - e);
							w.has_next_break = 1'b1;
						end else if (cfg_period != 0) begin
							w.next_break = sat_sum(t, cfg_period - el);
							w.has_next_break = 1'b1;
						end
					end
				end
			end
		end
		return w;
	endfunction

	// sample source: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_ch.valid <= 1'b0;
			smp_ch.sample_time <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!smp_ch.valid || smp_ch.ready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				smp_ch.valid <= 1'b0;
			end else if (sample_q.size() != 0 && !hold_send) begin
				next_time = sample_q.pop_front();
				smp_ch.valid <= 1'b1;
				smp_ch.sample_time <= next_time;
				pulse_q.push_back(pulse_at(next_time));
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				smp_ch.valid <= 1'b0;
			end
		end
	end

	// result sink: random stalls at a stall rate that is redrawn periodically
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_pct <= 0;
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt % 300 == 0)
				stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
			res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			if (res_ch.valid && res_ch.ready) begin
				if (pulse_q.size() == 0) begin
					$error("result word with nothing expected");
					mismatch_count++;
				end else begin
					pulse_word_t w;
					w = pulse_q.pop_front();
					if (res_ch.level !== w.level) begin
						$error("level: expected %h, got %h", w.level, res_ch.level);
						mismatch_count++;
					end
					if (res_ch.next_break !== w.next_break) begin
						$error("next_break: expected %h, got %h", w.next_break,
							res_ch.next_break);
						mismatch_count++;
					end
					if (res_ch.has_next_break !== w.has_next_break) begin
						$error("has_next_break: expected %b, got %b", w.has_next_break,
							res_ch.has_next_break);
						mismatch_count++;
					end
					if (res_ch.config_error !== w.config_error) begin
						$error("config_error: expected %0d, got %0d", w.config_error,
							res_ch.config_error);
						mismatch_count++;
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_START_DELAY:   cfg_delay = val[TB-1:0];
			REG_LOW_LEVEL:     cfg_low = val[LB-1:0];
			REG_HIGH_LEVEL:    cfg_high = val[LB-1:0];
			REG_REPEAT_PERIOD: cfg_period = val[TB-1:0];
			REG_RISE_TIME:     cfg_rise = val[TB-1:0];
			REG_FALL_TIME:     cfg_fall = val[TB-1:0];
			REG_TOP_WIDTH:     cfg_width = val[TB-1:0];
			default: ;
		endcase
	endtask

	task automatic load_pulse(input logic [TB-1:0] dly, input logic [LB-1:0] lo,
			input logic [LB-1:0] hi, input logic [TB-1:0] per, input logic [TB-1:0] rise,
			input logic [TB-1:0] fall, input logic [TB-1:0] width);
		write_reg(REG_START_DELAY, 64'(dly));
		write_reg(REG_LOW_LEVEL, 64'(lo));
		write_reg(REG_HIGH_LEVEL, 64'(hi));
		write_reg(REG_REPEAT_PERIOD, 64'(per));
		write_reg(REG_RISE_TIME, 64'(rise));
		write_reg(REG_FALL_TIME, 64'(fall));
		write_reg(REG_TOP_WIDTH, 64'(width));
	endtask

	task automatic drain;
		while (sample_q.size() != 0 || pulse_q.size() != 0)
			@(posedge clk);
	endtask

	// sample times clustered around the corners of the first few periods
	function automatic logic [TB-1:0] pick_time();
		logic [TB-1:0] corner, k;
		case ($urandom_range(0, 9))
			0: return TB'({$urandom, $urandom});
			1: return $urandom_range(0, 1) ? TMAX : '0;
			default: begin
				k = TB'($urandom_range(0, 3));
				case ($urandom_range(0, 4))
					0: corner = '0;
					1: corner = cfg_rise;
					2: corner = cfg_rise + cfg_width;
					3: corner = cfg_rise + cfg_width + cfg_fall;
					default: corner = cfg_period;
				endcase
				return cfg_delay + k * cfg_period + corner + TB'($urandom_range(0, 4))
					- TB'(2);
			end
		endcase
	endfunction

	task automatic random_samples(input int n);
		repeat (n) sample_q.push_back(pick_time());
	endtask

	initial begin
		logic [TB-1:0] r, f, w;
		mismatch_count = 0;
		hold_send = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_delay = '0;
		cfg_low = '0;
		cfg_high = LB'(65536);
		cfg_period = '0;
		cfg_rise = TB'(1000);
		cfg_fall = '0;
		cfg_width = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// defaults: single rise with the top held forever
		for (int i = 0; i < TB; i++) sample_q.push_back(TB'(1) << i);
		sample_q.push_back('0);
		sample_q.push_back(TB'(999));
		sample_q.push_back(TB'(1000));
		sample_q.push_back(TMAX);
		drain();

		// periodic pulse, rising from below zero
		load_pulse(100, 32'hFFFF_0000, 32'h0002_0000, 1000, 100, 200, 300);
		for (int i = 95; i < 110; i++) sample_q.push_back(TB'(i));
		random_samples(150);
		drain();
		// hold the source until the pipeline is empty
		random_samples(100);
		repeat (20) @(posedge clk);
		hold_send = 1'b1;
		while (pulse_q.size() != 0) @(posedge clk);
		hold_send = 1'b0;
		drain();

		// zero rise time is rejected
		load_pulse(0, 32'h1234_5678, 32'h0001_0000, 0, 0, 5, 5);
		random_samples(40);
		drain();

		// period equal to rise + fall + top is rejected
		load_pulse(10, 0, 32'h0001_0000, 600, 100, 200, 300);
		random_samples(40);
		drain();

		// period at the maximum but the sum overflows and saturates
		load_pulse(0, 0, 32'h0001_0000, TMAX, TMAX - 10, 20, 5);
		random_samples(40);
		drain();

		// full level swing over the longest edges; corners past the range saturate
		load_pulse(0, 32'h8000_0000, 32'h7FFF_FFFF, 0, TMAX, TMAX, TMAX);
		random_samples(120);
		drain();
		load_pulse(TMAX - 5, 32'h7FFF_FFFF, 32'h8000_0000, TMAX, 3, 1, 1);
		random_samples(120);
		drain();

		// short single pulse falling below the base level
		load_pulse(5, 32'h0003_0000, 32'hFFFE_8000, 0, 3, 2, 4);
		for (int i = 0; i < 20; i++) sample_q.push_back(TB'(i));
		random_samples(100);
		drain();

		// random small settings, mostly valid
		repeat (8) begin
			r = TB'($urandom_range(1, 20));
			f = ($urandom_range(0, 2) == 0) ? '0 : TB'($urandom_range(1, 20));
			w = TB'($urandom_range(0, 20));
			load_pulse(TB'($urandom_range(0, 50)), $urandom, $urandom,
				($urandom_range(0, 2) == 0) ? '0
					: r + f + w + TB'($urandom_range(0, 30)) + TB'(1),
				($urandom_range(0, 15) == 0) ? '0 : r, f, w);
			random_samples(170);
			drain();
		end

		repeat (120) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/tpwg_pkg.sv
rtl/core/tpwg_ifs.sv
rtl/core/tpwg_cfg.sv
rtl/core/tpwg_mod.sv
rtl/core/tpwg_seg.sv
rtl/core/tpwg_interp.sv
rtl/core/trapezoid_pulse_waveform_generator_unit.sv
sim/trapezoid_pulse_waveform_generator_unit_tb.sv
